FILE: hw/rtl/trqd_pkg.sv
// ----------------------------------------------------------------------------
// trqd_pkg
// Shared types and constants for the timed repeat queue with duplicate
// suppression: register map, result kinds, controller states, command and
// status bundles.
// ----------------------------------------------------------------------------
package trqd_pkg;

	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 12;
	localparam int MS_W         = 22;    // 4095 s * 1000 fits in 22 bits
	localparam int MS_PER_SEC   = 1000;
	localparam int RESULT_LIMIT = 8;     // max releases per tick
	localparam int CNT_W        = 4;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DUPE_WINDOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY = 2'd2;

	localparam logic [CFG_DATA_W-1:0] DUPE_WINDOW_RESET  = 12'd30;
	localparam logic [CFG_DATA_W-1:0] REPEAT_DELAY_RESET = 12'd0;

	localparam logic OP_OFFER = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	typedef enum logic [2:0] {
		KIND_QUEUED    = 3'd0,
		KIND_IGNORED   = 3'd1,
		KIND_DUPLICATE = 3'd2,
		KIND_RELEASED  = 3'd3,
		KIND_NONE_DUE  = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_SCAN,
		ST_RESOLVE,
		ST_RELEASE
	} state_t;

	typedef struct packed {
		logic load;     // latch the input item
		logic prep;     // precompute thresholds, clear scan results
		logic scan;     // examine one slot
		logic resolve;  // load the single result (and commit an offer)
		logic emit;     // load a release result for the current slot
		logic skip;     // step past a slot that is not released
	} cmd_t;

	typedef struct packed {
		logic ign;
		logic op_tick;
		logic scan_last;
		logic mask_empty;
		logic rel_hit;
		logic rel_last;
		logic out_free;
	} sts_t;

endpackage

FILE: hw/rtl/trqd_regs.sv
// ----------------------------------------------------------------------------
// trqd_regs
// Configuration registers. Keeps the enable bit and the two second counts,
// and registered millisecond versions of the window and the delay.
// ----------------------------------------------------------------------------
module trqd_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [trqd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [trqd_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                            enable,
	output logic [trqd_pkg::MS_W-1:0]       window_ms,
	output logic [trqd_pkg::MS_W-1:0]       delay_ms
);
	import trqd_pkg::*;

	logic                  enable_q;
	logic [CFG_DATA_W-1:0] window_sec_q;
	logic [CFG_DATA_W-1:0] delay_sec_q;
	logic [MS_W-1:0]       window_ms_q;
	logic [MS_W-1:0]       delay_ms_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= 1'b0;
			window_sec_q <= DUPE_WINDOW_RESET;
			delay_sec_q  <= REPEAT_DELAY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ENABLE:       enable_q     <= cfg_data[0];
				REG_DUPE_WINDOW:  window_sec_q <= cfg_data;
				REG_REPEAT_DELAY: delay_sec_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// seconds to ms, registered from the second counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_ms_q <= MS_W'(int'(DUPE_WINDOW_RESET) * MS_PER_SEC);
			delay_ms_q  <= MS_W'(int'(REPEAT_DELAY_RESET) * MS_PER_SEC);
		end else begin
			window_ms_q <= MS_W'(window_sec_q) * MS_W'(MS_PER_SEC);
			delay_ms_q  <= MS_W'(delay_sec_q) * MS_W'(MS_PER_SEC);
		end
	end

	assign enable    = enable_q;
	assign window_ms = window_ms_q;
	assign delay_ms  = delay_ms_q;

endmodule

FILE: hw/rtl/trqd_ctrl.sv
// ----------------------------------------------------------------------------
// trqd_ctrl
// Controller: sequences latch, precompute, slot scan, release walk and
// result loading.
// ----------------------------------------------------------------------------
module trqd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  trqd_pkg::sts_t sts,
	output trqd_pkg::cmd_t cmd
);
	import trqd_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) state_d = ST_PREP;
			end
			ST_PREP: begin
				state_d = sts.ign ? ST_RESOLVE : ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.scan_last) state_d = sts.op_tick ? ST_RELEASE : ST_RESOLVE;
			end
			ST_RESOLVE: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			ST_RELEASE: begin
				if (sts.mask_empty) begin
					state_d = ST_RESOLVE;
				end else if (sts.rel_hit && sts.out_free && sts.rel_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		item_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				cmd.load   = item_valid;
			end
			ST_PREP:    cmd.prep    = 1'b1;
			ST_SCAN:    cmd.scan    = 1'b1;
			ST_RESOLVE: cmd.resolve = sts.out_free;
			ST_RELEASE: begin
				if (!sts.mask_empty) begin
					if (sts.rel_hit) begin
						cmd.emit = sts.out_free;
					end else begin
						cmd.skip = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: hw/rtl/trqd_dp.sv
// ----------------------------------------------------------------------------
// trqd_dp
// Datapath: latched item, slot store, per-slot scan logic (duplicate check,
// free slot, earliest due, due mask) and the result register.
// ----------------------------------------------------------------------------
module trqd_dp #(
	parameter int QUEUE_DEPTH = 8,
	parameter int ALIAS_SLOTS = 8,
	parameter int TIME_BITS   = 48
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  trqd_pkg::cmd_t            cmd,
	output trqd_pkg::sts_t            sts,
	input  logic                      enable,
	input  logic [trqd_pkg::MS_W-1:0] window_ms,
	input  logic [trqd_pkg::MS_W-1:0] delay_ms,
	input  logic                      op,
	input  logic [TIME_BITS-1:0]      now_ms,
	input  logic                      alias_found,
	input  logic [7:0]                frame_crc,
	input  logic [2:0]                alias_index,
	input  logic [2:0]                path_position,
	input  logic [7:0]                frame_handle,
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic [2:0]                kind,
	output logic [2:0]                slot,
	output logic                      evicted,
	output logic [7:0]                out_handle,
	output logic [2:0]                out_alias,
	output logic [2:0]                out_position,
	output logic                      last
);
	import trqd_pkg::*;

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

	// slot store
	logic [QUEUE_DEPTH-1:0] waiting_q;
	logic [TIME_BITS-1:0]   ent_due_q    [QUEUE_DEPTH];
	logic [TIME_BITS-1:0]   ent_queued_q [QUEUE_DEPTH];
	logic [7:0]             ent_crc_q    [QUEUE_DEPTH];
	logic [7:0]             ent_handle_q [QUEUE_DEPTH];
	logic [2:0]             ent_alias_q  [QUEUE_DEPTH];
	logic [2:0]             ent_pos_q    [QUEUE_DEPTH];

	// latched item
	logic                 op_q;
	logic                 ign_q;
	logic [TIME_BITS-1:0] now_q;
	logic [7:0]           crc_q;
	logic [2:0]           alias_q;
	logic [2:0]           pos_q;
	logic [7:0]           handle_q;

	// precomputed per item
	logic [TIME_BITS-1:0] lo_q;
	logic                 under_q;
	logic [TIME_BITS-1:0] due_new_q;

	// scan state
	logic [IDX_W-1:0]       idx_q;
	logic                   dup_q;
	logic                   free_found_q;
	logic [IDX_W-1:0]       free_idx_q;
	logic [IDX_W-1:0]       best_idx_q;
	logic [TIME_BITS-1:0]   best_due_q;
	logic [QUEUE_DEPTH-1:0] mask_q;
	logic [CNT_W-1:0]       cnt_q;

	// result register
	logic       res_valid_q;
	logic [2:0] res_kind_q;
	logic [2:0] res_slot_q;
	logic       res_evicted_q;
	logic [7:0] res_handle_q;
	logic [2:0] res_alias_q;
	logic [2:0] res_pos_q;
	logic       res_last_q;

	logic                   ign_d;
	logic [TIME_BITS:0]     due_sum;
	logic [TIME_BITS-1:0]   ent_due;
	logic [TIME_BITS-1:0]   ent_queued;
	logic                   dup_hit;
	logic                   due_hit;
	logic                   min_better;
	logic [IDX_W-1:0]       cslot;
	logic                   commit;
	logic                   step;
	logic [QUEUE_DEPTH-1:0] idx_bit;
	logic                   out_free;

	assign ign_d = (op == OP_OFFER)
		? (!enable || !alias_found || (5'(alias_index) >= 5'(ALIAS_SLOTS)))
		: !enable;

	assign due_sum = {1'b0, now_q} + (TIME_BITS + 1)'(delay_ms);

	assign ent_due    = ent_due_q[idx_q];
	assign ent_queued = ent_queued_q[idx_q];

	// age below window <=> queued after now - window (always, if now < window)
	assign dup_hit = waiting_q[idx_q] && (ent_crc_q[idx_q] == crc_q) &&
		(ent_queued <= now_q) && (under_q || (ent_queued > lo_q));
	assign due_hit = waiting_q[idx_q] && (now_q >= ent_due) &&
		(cnt_q < CNT_W'(RESULT_LIMIT));
	assign min_better = (idx_q == '0) || (ent_due < best_due_q);

	assign cslot   = free_found_q ? free_idx_q : best_idx_q;
	assign commit  = cmd.resolve && !ign_q && (op_q == OP_OFFER) && !dup_q;
	assign step    = cmd.scan || cmd.emit || cmd.skip;
	assign idx_bit = QUEUE_DEPTH'(1) << idx_q;
	assign out_free = !res_valid_q || !result_stall;

	always_comb begin
		sts            = '0;
		sts.ign        = ign_q;
		sts.op_tick    = (op_q == OP_TICK);
		sts.scan_last  = (idx_q == IDX_LAST);
		sts.mask_empty = (mask_q == '0);
		sts.rel_hit    = mask_q[idx_q];
		sts.rel_last   = ((mask_q & ~idx_bit) == '0);
		sts.out_free   = out_free;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op;
			ign_q    <= ign_d;
			now_q    <= now_ms;
			crc_q    <= frame_crc;
			alias_q  <= alias_index;
			pos_q    <= path_position;
			handle_q <= frame_handle;
		end
		if (cmd.prep) begin
			lo_q      <= now_q - TIME_BITS'(window_ms);
			under_q   <= (now_q < TIME_BITS'(window_ms));
			due_new_q <= due_sum[TIME_BITS] ? '1 : due_sum[TIME_BITS-1:0];
		end
		if (cmd.scan) begin
			if (!waiting_q[idx_q] && !free_found_q) free_idx_q <= idx_q;
			if (min_better) begin
				best_idx_q <= idx_q;
				best_due_q <= ent_due;
			end
		end
		if (commit) begin
			ent_due_q[cslot]    <= due_new_q;
			ent_queued_q[cslot] <= now_q;
			ent_crc_q[cslot]    <= crc_q;
			ent_handle_q[cslot] <= handle_q;
			ent_alias_q[cslot]  <= alias_q;
			ent_pos_q[cslot]    <= pos_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q    <= '0;
			mask_q       <= '0;
			cnt_q        <= '0;
			idx_q        <= '0;
			dup_q        <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			if (cmd.prep) begin
				mask_q       <= '0;
				cnt_q        <= '0;
				idx_q        <= '0;
				dup_q        <= 1'b0;
				free_found_q <= 1'b0;
			end
			if (step) begin
				idx_q <= (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
			end
			if (cmd.scan) begin
				if (dup_hit) dup_q <= 1'b1;
				if (!waiting_q[idx_q]) free_found_q <= 1'b1;
				if (due_hit) begin
					mask_q[idx_q] <= 1'b1;
					cnt_q         <= cnt_q + 1'b1;
				end
			end
			if (cmd.emit) begin
				mask_q[idx_q]    <= 1'b0;
				waiting_q[idx_q] <= 1'b0;
			end
			if (commit) waiting_q[cslot] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.resolve || cmd.emit) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.resolve) begin
			res_slot_q    <= '0;
			res_evicted_q <= 1'b0;
			res_handle_q  <= '0;
			res_alias_q   <= '0;
			res_pos_q     <= '0;
			res_last_q    <= 1'b1;
			if (ign_q) begin
				res_kind_q <= KIND_IGNORED;
			end else if (op_q == OP_TICK) begin
				res_kind_q <= KIND_NONE_DUE;
			end else if (dup_q) begin
				res_kind_q <= KIND_DUPLICATE;
			end else begin
				res_kind_q    <= KIND_QUEUED;
				res_slot_q    <= 3'(cslot);
				res_evicted_q <= !free_found_q;
			end
		end else if (cmd.emit) begin
			res_kind_q    <= KIND_RELEASED;
			res_slot_q    <= 3'(idx_q);
			res_evicted_q <= 1'b0;
			res_handle_q  <= ent_handle_q[idx_q];
			res_alias_q   <= ent_alias_q[idx_q];
			res_pos_q     <= ent_pos_q[idx_q];
			res_last_q    <= ((mask_q & ~idx_bit) == '0);
		end
	end

	assign result_valid = res_valid_q;
	assign kind         = res_kind_q;
	assign slot         = res_slot_q;
	assign evicted      = res_evicted_q;
	assign out_handle   = res_handle_q;
	assign out_alias    = res_alias_q;
	assign out_position = res_pos_q;
	assign last         = res_last_q;

`ifndef SYNTH
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.resolve || cmd.emit) |-> (!res_valid_q || !result_stall))
		else $error("result loaded over an unaccepted result");

	a_emit_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> waiting_q[idx_q])
		else $error("release of a slot that is not waiting");

	a_mask_subset: assert property (@(posedge clk) disable iff (!arst_n)
		(mask_q & ~waiting_q) == '0)
		else $error("due mask marks a free slot");

	a_release_limit: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(mask_q) <= RESULT_LIMIT)
		else $error("too many slots marked for release");
`endif

endmodule

FILE: hw/rtl/timed_repeat_queue_dedup.sv
// ----------------------------------------------------------------------------
// timed_repeat_queue_dedup
// Slotted repeat queue: queues matching frame offers unless a recent entry
// has the same checksum, and releases due entries on a time tick.
// ----------------------------------------------------------------------------
// Sequence: an offer is latched, its thresholds precomputed and every slot
//   scanned in turn before its result is loaded; an ignored item skips the
//   scan. A tick scans all slots, then walks them one slot per cycle unless
//   a result stall holds it, loading a release result for each due slot.
// Accepts no new item until the last is done: item_stall stays high until
//   its result, or a tick's last release result, has been loaded.
// Reset: clears the slot waiting bits, controller and registers; no sweep.
module timed_repeat_queue_dedup #(
	parameter int QUEUE_DEPTH = 8,
	parameter int ALIAS_SLOTS = 8,
	parameter int TIME_BITS   = 48
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [trqd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [trqd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic                            op,
	input  logic [TIME_BITS-1:0]            now_ms,
	input  logic                            alias_found,
	input  logic [7:0]                      frame_crc,
	input  logic [2:0]                      alias_index,
	input  logic [2:0]                      path_position,
	input  logic [7:0]                      frame_handle,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [2:0]                      kind,
	output logic [2:0]                      slot,
	output logic                            evicted,
	output logic [7:0]                      out_handle,
	output logic [2:0]                      out_alias,
	output logic [2:0]                      out_position,
	output logic                            last
);
	import trqd_pkg::*;

	logic            enable;
	logic [MS_W-1:0] window_ms;
	logic [MS_W-1:0] delay_ms;
	cmd_t            cmd;
	sts_t            sts;

	trqd_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.enable    (enable),
		.window_ms (window_ms),
		.delay_ms  (delay_ms)
	);

	trqd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	trqd_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ALIAS_SLOTS (ALIAS_SLOTS),
		.TIME_BITS   (TIME_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.enable        (enable),
		.window_ms     (window_ms),
		.delay_ms      (delay_ms),
		.op            (op),
		.now_ms        (now_ms),
		.alias_found   (alias_found),
		.frame_crc     (frame_crc),
		.alias_index   (alias_index),
		.path_position (path_position),
		.frame_handle  (frame_handle),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.kind          (kind),
		.slot          (slot),
		.evicted       (evicted),
		.out_handle    (out_handle),
		.out_alias     (out_alias),
		.out_position  (out_position),
		.last          (last)
	);

endmodule
